FILE: rtl/hufd_pkg.sv
// hufd_pkg: shared types, codes and defaults for the huffman tree bit decoder
// no dependencies; used by every module of the block but hufd_ram
`timescale 1ns / 1ps

package hufd_pkg;

    localparam int NODE_SLOTS_DEF  = 1024;
    localparam int SYMBOL_BITS_DEF = 9;

    localparam int IDX_W  = 10;
    localparam int ISYM_W = 9;
    localparam int OSYM_W = 8;
    localparam int CFG_W  = 10;

    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_BIT     = 2'd1;
    localparam logic [1:0] FUNC_END     = 2'd2;
    localparam logic [1:0] FUNC_RESTART = 2'd3;

    localparam logic [1:0] KIND_SYMBOL = 2'd0;
    localparam logic [1:0] KIND_EOM    = 2'd1;
    localparam logic [1:0] KIND_TRUNC  = 2'd2;

    localparam logic CFG_ROOT = 1'b0;
    localparam logic CFG_END  = 1'b1;

    localparam logic [ISYM_W-1:0] END_SYMBOL_RST = 9'd256;

    typedef struct packed {
        logic [1:0]        func;
        logic [IDX_W-1:0]  node_index;
        logic              node_is_leaf;
        logic [ISYM_W-1:0] node_symbol;
        logic [IDX_W-1:0]  zero_child;
        logic [IDX_W-1:0]  one_child;
        logic              code_bit;
    } t_item;

    typedef struct packed {
        logic [OSYM_W-1:0] symbol;
        logic [1:0]        kind;
    } t_result;

    typedef struct packed {
        logic wr_node;
        logic restart;
        logic end_in;
        logic rd_cur;
        logic rd_child;
        logic decide;
    } t_cmd;

endpackage

FILE: rtl/hufd_ram.sv
// hufd_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module hufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/hufd_ctrl.sv
// hufd_ctrl: item sequencer for the huffman tree bit decoder
// depends on hufd_pkg for function codes and the command struct
`timescale 1ns / 1ps

module hufd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic [1:0]    i_func,
    input  logic          i_finished,
    output logic          busy,
    output hufd_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CUR   = 2'd1;
    localparam logic [1:0] S_CHILD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_func)
                        hufd_pkg::FUNC_WRITE:   o_cmd.wr_node = 1'b1;
                        hufd_pkg::FUNC_RESTART: o_cmd.restart = 1'b1;
                        hufd_pkg::FUNC_END:     o_cmd.end_in  = 1'b1;
                        hufd_pkg::FUNC_BIT: begin
                            // bits are dropped once the message has ended
                            if (!i_finished) begin
                                o_cmd.rd_cur = 1'b1;
                                n_state      = S_CUR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CUR: begin
                o_cmd.rd_child = 1'b1;
                n_state        = S_CHILD;
            end
            S_CHILD: begin
                o_cmd.decide = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/hufd_dp.sv
// hufd_dp: node store, cursor, config registers and result register
// depends on hufd_pkg and hufd_ram
`timescale 1ns / 1ps

module hufd_dp #(
    parameter int NODE_SLOTS  = hufd_pkg::NODE_SLOTS_DEF,
    parameter int SYMBOL_BITS = hufd_pkg::SYMBOL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hufd_pkg::t_cmd               i_cmd,
    input  hufd_pkg::t_item              i_item,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [hufd_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                         o_finished,
    output logic                         o_valid,
    output hufd_pkg::t_result            o_result
);

    localparam int IW      = hufd_pkg::IDX_W;
    localparam int AW      = $clog2(NODE_SLOTS);
    localparam int ENTRY_W = 1 + SYMBOL_BITS + 2 * IW;
    localparam int LEAF_B  = ENTRY_W - 1;
    localparam int SYM_LO  = 2 * IW;

    logic [IW-1:0]                   r_root;
    logic [hufd_pkg::ISYM_W-1:0]     r_end;
    logic [IW-1:0]                   r_cursor;
    logic                            r_finished;
    logic                            r_bit;
    logic                            r_cur_ok;
    logic [IW-1:0]                   r_next;
    logic                            r_child_ok;
    logic                            r_valid;
    hufd_pkg::t_result               r_result;

    logic [ENTRY_W-1:0]   wdata;
    logic                 we;
    logic                 re;
    logic [AW-1:0]        raddr;
    logic [ENTRY_W-1:0]   rdata;
    logic [IW-1:0]        next_idx;
    logic                 child_leaf;
    logic [SYMBOL_BITS-1:0] child_sym;
    logic                 is_end;

    assign wdata = {i_item.node_is_leaf, SYMBOL_BITS'(i_item.node_symbol),
                    i_item.zero_child, i_item.one_child};
    // writes past the store are dropped
    assign we = i_cmd.wr_node && (32'(i_item.node_index) < 32'(NODE_SLOTS));
    assign re = i_cmd.rd_cur || i_cmd.rd_child;

    // an out of range cursor reads as an inner node with both children zero
    assign next_idx = !r_cur_ok ? '0 :
                      r_bit     ? rdata[IW-1:0] : rdata[SYM_LO-1:IW];

    assign raddr = i_cmd.rd_child ? AW'(next_idx) : AW'(r_cursor);

    assign child_leaf = r_child_ok && rdata[LEAF_B];
    assign child_sym  = rdata[LEAF_B-1:SYM_LO];
    assign is_end     = (child_sym == SYMBOL_BITS'(r_end));

    hufd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (AW'(i_item.node_index)),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root     <= '0;
            r_end      <= hufd_pkg::END_SYMBOL_RST;
            r_cursor   <= '0;
            r_finished <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= (i_cmd.end_in && !r_finished) || (i_cmd.decide && child_leaf);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hufd_pkg::CFG_ROOT: begin
                        r_root   <= i_cfg_data[IW-1:0];
                        r_cursor <= i_cfg_data[IW-1:0];
                    end
                    hufd_pkg::CFG_END: r_end <= i_cfg_data[hufd_pkg::ISYM_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.restart) begin
                r_cursor   <= r_root;
                r_finished <= 1'b0;
            end
            if (i_cmd.end_in && !r_finished) begin
                r_finished <= 1'b1;
            end
            if (i_cmd.decide) begin
                if (!child_leaf) begin
                    r_cursor <= r_next;
                end else if (is_end) begin
                    // cursor parks on the end leaf
                    r_cursor   <= r_next;
                    r_finished <= 1'b1;
                end else begin
                    r_cursor <= r_root;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_cur) begin
            r_bit    <= i_item.code_bit;
            r_cur_ok <= (32'(r_cursor) < 32'(NODE_SLOTS));
        end
        if (i_cmd.rd_child) begin
            r_next     <= next_idx;
            r_child_ok <= (32'(next_idx) < 32'(NODE_SLOTS));
        end
        if (i_cmd.end_in) begin
            r_result.symbol <= '0;
            r_result.kind   <= hufd_pkg::KIND_TRUNC;
        end
        if (i_cmd.decide) begin
            if (is_end) begin
                r_result.symbol <= '0;
                r_result.kind   <= hufd_pkg::KIND_EOM;
            end else begin
                r_result.symbol <= hufd_pkg::OSYM_W'(child_sym);
                r_result.kind   <= hufd_pkg::KIND_SYMBOL;
            end
        end
    end

    assign o_finished = r_finished;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

endmodule

FILE: rtl/huffman_tree_bit_decoder_top.sv
// huffman_tree_bit_decoder_top: top level of the huffman tree bit decoder
// depends on hufd_pkg, hufd_ctrl, hufd_dp and hufd_ram
`timescale 1ns / 1ps

// Bit-serial Huffman tree-walk decoder. Load the code tree with write-node items,
// then feed one code bit per decode item. A write-node, restart or end-of-input
// item leaves busy low; a decode-bit item, unless the message has ended, holds
// busy through S_CUR and S_CHILD for its two dependent node-store reads, the
// current node to pick a child, then the child to test for a leaf, on the one
// read port of the store. A result shows on o_valid/o_result for exactly one
// cycle, the cycle after the item's last step, and cannot be held off; a new
// item may be started in that same cycle. Configuration writes belong in idle
// time; writing root_index also moves the cursor to the new root. Node store
// contents are undefined until written, and there is no clearing pass after reset.
module huffman_tree_bit_decoder_top #(
    parameter int NODE_SLOTS  = hufd_pkg::NODE_SLOTS_DEF,
    parameter int SYMBOL_BITS = hufd_pkg::SYMBOL_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  hufd_pkg::t_item            i_item,
    output logic                       o_valid,
    output hufd_pkg::t_result          o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [hufd_pkg::CFG_W-1:0] i_cfg_data
);

    hufd_pkg::t_cmd cmd;
    logic           finished;

    assign o_cfg_ready = 1'b1;

    hufd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_func     (i_item.func),
        .i_finished (finished),
        .busy       (busy),
        .o_cmd      (cmd)
    );

    hufd_dp #(
        .NODE_SLOTS  (NODE_SLOTS),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_finished  (finished),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule

FILE: test/tb_huffman_tree_bit_decoder_top.sv
// tb_huffman_tree_bit_decoder_top: self-checking bench for the huffman tree bit decoder
// loads random code trees, streams codeword bits and checks each result against a tree walk
// depends on hufd_pkg and huffman_tree_bit_decoder_top
`timescale 1ns / 1ps

module tb_huffman_tree_bit_decoder_top;
    import hufd_pkg::*;

    localparam int SLOTS    = NODE_SLOTS_DEF;
    localparam int MAX_TREE = 128;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_item            i_item      = '0;
    logic             o_valid;
    t_result          o_result;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic             i_cfg_index = CFG_ROOT;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    huffman_tree_bit_decoder_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // shadow of the decoder state
    logic              mem_leaf [SLOTS];
    logic [ISYM_W-1:0] mem_sym  [SLOTS];
    logic [IDX_W-1:0]  mem_zero [SLOTS];
    logic [IDX_W-1:0]  mem_one  [SLOTS];
    logic [IDX_W-1:0]  root_reg   = '0;
    logic [ISYM_W-1:0] end_reg    = END_SYMBOL_RST;
    logic [IDX_W-1:0]  cursor_q   = '0;
    logic              finished_q = 1'b0;

    t_result due_symbols[$];
    t_item   send_q[$];
    int      n_err     = 0;
    int      n_queued  = 0;
    int      idle_left = 0;
    bit      calm      = 1'b0;

    // stimulus side view of the node store and the current code tree
    bit               known_map [SLOTS];
    int               known_nodes[$];
    bit               in_tree [SLOTS];
    int               tr_idx    [MAX_TREE];
    bit               tr_leaf   [MAX_TREE];
    int               tr_parent [MAX_TREE];
    bit               tr_side   [MAX_TREE];
    logic [IDX_W-1:0] tr_zero   [MAX_TREE];
    logic [IDX_W-1:0] tr_one    [MAX_TREE];
    int               tr_n;
    int               tips[$];
    int               end_tip;

    task automatic walk_tree(input t_item it);
        logic [IDX_W-1:0] nxt;
        t_result          r;
        r = '0;
        case (it.func)
            FUNC_WRITE: begin
                mem_leaf[it.node_index] = it.node_is_leaf;
                mem_sym[it.node_index]  = it.node_symbol;
                mem_zero[it.node_index] = it.zero_child;
                mem_one[it.node_index]  = it.one_child;
            end
            FUNC_RESTART: begin
                cursor_q   = root_reg;
                finished_q = 1'b0;
            end
            FUNC_END: begin
                if (!finished_q) begin
                    finished_q = 1'b1;
                    r.kind     = KIND_TRUNC;
                    due_symbols.insert(due_symbols.size(), r);
                end
            end
            default: begin
                if (!finished_q) begin
                    nxt = it.code_bit ? mem_one[cursor_q] : mem_zero[cursor_q];
                    if (!mem_leaf[nxt]) begin
                        cursor_q = nxt;
                    end else if (mem_sym[nxt] == end_reg) begin
                        // cursor parks on the end leaf
                        cursor_q   = nxt;
                        finished_q = 1'b1;
                        r.kind     = KIND_EOM;
                        due_symbols.insert(due_symbols.size(), r);
                    end else begin
                        cursor_q = root_reg;
                        r.symbol = mem_sym[nxt][OSYM_W-1:0];
                        r.kind   = KIND_SYMBOL;
                        due_symbols.insert(due_symbols.size(), r);
                    end
                end
            end
        endcase
    endtask

    function automatic t_item rand_item();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_item)-1:0];
    endfunction

    task automatic push_op(input logic [1:0] f, input logic b);
        t_item it;
        it          = rand_item();
        it.func     = f;
        it.code_bit = b;
        send_q.insert(send_q.size(), it);
        n_queued++;
    endtask

    task automatic push_node(input int idx, input bit leaf, input logic [ISYM_W-1:0] sym,
                             input int z, input int o);
        t_item it;
        it              = rand_item();
        it.func         = FUNC_WRITE;
        it.node_index   = idx[IDX_W-1:0];
        it.node_is_leaf = leaf;
        it.node_symbol  = sym;
        it.zero_child   = z[IDX_W-1:0];
        it.one_child    = o[IDX_W-1:0];
        send_q.insert(send_q.size(), it);
        n_queued++;
        if (!known_map[idx]) begin
            known_map[idx] = 1'b1;
            known_nodes.insert(known_nodes.size(), idx);
        end
    endtask

    function automatic int any_known();
        return known_nodes[$urandom_range(0, known_nodes.size() - 1)];
    endfunction

    function automatic int fresh_index();
        int idx;
        do idx = $urandom_range(0, SLOTS - 1); while (in_tree[idx]);
        return idx;
    endfunction

    // random full binary tree with k leaves; every child field names a written node
    task automatic build_tree(input int root, input logic [ISYM_W-1:0] endsym, input int k);
        int               p, pos, c;
        logic [ISYM_W-1:0] sym;
        foreach (in_tree[i]) in_tree[i] = 1'b0;
        tips.delete();
        tr_n         = 1;
        tr_idx[0]    = root;
        tr_leaf[0]   = 1'b1;
        tr_parent[0] = -1;
        tr_side[0]   = 1'b0;
        in_tree[root] = 1'b1;
        tips.insert(tips.size(), 0);
        repeat (k - 1) begin
            pos = $urandom_range(0, tips.size() - 1);
            p   = tips[pos];
            tips.delete(pos);
            tr_leaf[p] = 1'b0;
            for (int s = 0; s < 2; s++) begin
                c = tr_n;
                tr_n++;
                tr_idx[c]    = fresh_index();
                in_tree[tr_idx[c]] = 1'b1;
                tr_leaf[c]   = 1'b1;
                tr_parent[c] = p;
                tr_side[c]   = s[0];
                if (s == 0) tr_zero[p] = tr_idx[c][IDX_W-1:0];
                else        tr_one[p]  = tr_idx[c][IDX_W-1:0];
                tips.insert(tips.size(), c);
            end
        end
        end_tip = tips[$urandom_range(0, tips.size() - 1)];
        for (int i = 0; i < tr_n; i++) begin
            sym = ISYM_W'($urandom_range(0, (1 << ISYM_W) - 1));
            if (tr_leaf[i]) begin
                tr_zero[i] = tr_idx[$urandom_range(0, tr_n - 1)][IDX_W-1:0];
                tr_one[i]  = tr_idx[$urandom_range(0, tr_n - 1)][IDX_W-1:0];
                if (i == end_tip) sym = endsym;
            end
            push_node(tr_idx[i], tr_leaf[i], sym, int'(tr_zero[i]), int'(tr_one[i]));
        end
    endtask

    task automatic send_code(input int leaf_pos);
        bit path[$];
        int x;
        x = leaf_pos;
        while (tr_parent[x] >= 0) begin
            path.push_front(tr_side[x]);
            x = tr_parent[x];
        end
        foreach (path[i]) push_op(FUNC_BIT, path[i]);
    endtask

    task automatic push_noise();
        int idx;
        case ($urandom_range(0, 3))
            0: push_op(FUNC_BIT, 1'($urandom_range(0, 1)));
            1: push_op(FUNC_RESTART, 1'($urandom_range(0, 1)));
            2: push_op(FUNC_END, 1'($urandom_range(0, 1)));
            default: begin
                // stray node write outside the live tree
                do idx = $urandom_range(0, SLOTS - 1); while (in_tree[idx]);
                push_node(idx, 1'($urandom_range(0, 1)),
                          ISYM_W'($urandom_range(0, (1 << ISYM_W) - 1)),
                          any_known(), any_known());
            end
        endcase
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_ROOT) begin
            root_reg = data;
            cursor_q = data;
        end else begin
            end_reg = data[ISYM_W-1:0];
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        int guard;
        guard = 0;
        do @(posedge i_clk); while (send_q.size() != 0 || start);
        while (due_symbols.size() != 0 && guard < 400) begin
            @(posedge i_clk);
            guard++;
        end
        // items with no result may still be in flight
        repeat (6) @(posedge i_clk);
        if (due_symbols.size() != 0) begin
            $error("%0d expected results never arrived", due_symbols.size());
            n_err += due_symbols.size();
            due_symbols.delete();
        end
    endtask

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 79) == 0) calm = ~calm;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // item driver
    always @(posedge i_clk) begin
        logic fire;
        fire = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (fire) begin
                walk_tree(i_item);
                idle_left = pick_gap();
            end
            if (!start || fire) begin
                if (idle_left == 0 && send_q.size() != 0) begin
                    start  <= 1'b1;
                    i_item <= send_q.pop_front();
                end else begin
                    start <= 1'b0;
                    if (idle_left > 0) idle_left--;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (due_symbols.size() == 0) begin
                $error("unexpected result: symbol %0d kind %0d", o_result.symbol, o_result.kind);
                n_err++;
            end else begin
                want = due_symbols.pop_front();
                if (o_result.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_result.kind);
                    n_err++;
                end
                if (o_result.symbol !== want.symbol) begin
                    $error("symbol: expected %0d, got %0d", want.symbol, o_result.symbol);
                    n_err++;
                end
            end
        end
    end

    initial begin
        int                k, n_msg, n_sym, t, rt;
        logic [ISYM_W-1:0] es;
        logic [CFG_W-1:0]  end_data;
        bit                skip_restart;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // small hand-built tree at the reset root, reset end symbol
        push_node(0, 1'b0, 9'd0, 1, 2);
        push_node(1, 1'b1, 9'd0, 0, 0);
        push_node(2, 1'b0, 9'd0, 3, 4);
        push_node(3, 1'b1, 9'h1FF, 1023, 1023);
        push_node(4, 1'b1, END_SYMBOL_RST, 2, 1);
        push_node(1023, 1'b1, 9'h1A5, 0, 1023);
        push_node(512, 1'b0, 9'd0, 0, 0);
        push_op(FUNC_BIT, 1'b0);
        push_op(FUNC_BIT, 1'b1);
        push_op(FUNC_BIT, 1'b0);
        push_op(FUNC_BIT, 1'b1);
        push_op(FUNC_BIT, 1'b1);
        push_op(FUNC_BIT, 1'b1);
        push_op(FUNC_END, 1'b0);
        push_op(FUNC_RESTART, 1'b1);
        push_op(FUNC_BIT, 1'b1);
        push_op(FUNC_END, 1'b1);
        push_op(FUNC_BIT, 1'b0);
        push_op(FUNC_RESTART, 1'b0);
        push_op(FUNC_END, 1'b0);
        push_op(FUNC_RESTART, 1'b0);
        push_op(FUNC_BIT, 1'b1);
        push_op(FUNC_BIT, 1'b1);

        // root at the top slot, end symbol zero; finished carries over the root write
        settle();
        write_reg(CFG_ROOT, 10'd1023);
        write_reg(CFG_END, 10'd0);
        push_op(FUNC_BIT, 1'b1);
        push_op(FUNC_RESTART, 1'b0);
        push_op(FUNC_BIT, 1'b1);
        push_op(FUNC_BIT, 1'b0);
        push_op(FUNC_BIT, 1'b0);

        while (n_queued < 1050) begin
            settle();
            case ($urandom_range(0, 9))
                0:       rt = 0;
                1:       rt = SLOTS - 1;
                default: rt = $urandom_range(0, SLOTS - 1);
            endcase
            case ($urandom_range(0, 9))
                0:       es = '0;
                1:       es = '1;
                2:       es = END_SYMBOL_RST;
                default: es = ISYM_W'($urandom_range(0, (1 << ISYM_W) - 1));
            endcase
            end_data = {1'($urandom_range(0, 1)), es};
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_ROOT, rt[IDX_W-1:0]);
                write_reg(CFG_END, end_data);
            end else begin
                write_reg(CFG_END, end_data);
                write_reg(CFG_ROOT, rt[IDX_W-1:0]);
            end

            k = ($urandom_range(0, 99) < 85) ? $urandom_range(2, 10) : $urandom_range(11, 48);
            build_tree(rt, es, k);

            n_msg        = $urandom_range(2, 6);
            skip_restart = ($urandom_range(0, 9) < 3);
            for (int m = 0; m < n_msg; m++) begin
                if (m != 0 || !skip_restart) push_op(FUNC_RESTART, 1'($urandom_range(0, 1)));
                n_sym = $urandom_range(0, 10);
                repeat (n_sym) begin
                    if ($urandom_range(0, 99) < 12) push_noise();
                    do t = tips[$urandom_range(0, tips.size() - 1)]; while (t == end_tip);
                    send_code(t);
                end
                case ($urandom_range(0, 19))
                    0, 1, 2: push_op(FUNC_END, 1'($urandom_range(0, 1)));
                    3:       ;
                    default: send_code(end_tip);
                endcase
                // bits past the end mark, then a second end of input
                if ($urandom_range(0, 9) < 3) begin
                    repeat ($urandom_range(1, 3)) push_op(FUNC_BIT, 1'($urandom_range(0, 1)));
                    push_op(FUNC_END, 1'($urandom_range(0, 1)));
                end
            end
        end

        settle();
        if (n_err == 0) begin
            $display("tb_huffman_tree_bit_decoder_top: done, clean");
        end else begin
            $display("tb_huffman_tree_bit_decoder_top: done, errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_huffman_tree_bit_decoder_top: done, errors");
        $finish;
    end

endmodule
